@@ hdl/src_pkg.sv @@
package src_pkg;

  typedef struct packed {
    logic [19:0] raw_press;
    logic [19:0] raw_temp;
    logic [15:0] raw_hum;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] temp_centi;
    logic [31:0]        press_q24_8;
    logic [16:0]        hum_q22_10;
    logic               press_invalid;
  } out_item_t;

  // Calibration register indexes.
  localparam logic [2:0] CFG_CALIB_TEMP    = 3'd0;
  localparam logic [2:0] CFG_CALIB_PRESS_A = 3'd1;
  localparam logic [2:0] CFG_CALIB_PRESS_B = 3'd2;
  localparam logic [2:0] CFG_CALIB_PRESS_C = 3'd3;
  localparam logic [2:0] CFG_CALIB_HUM_A   = 3'd4;
  localparam logic [2:0] CFG_CALIB_HUM_B   = 3'd5;

  localparam int CFG_W     = 48;
  localparam int NUM_W     = 64;
  localparam int DEN_W     = 31;
  localparam int DIV_TAG_W = 96;

  localparam logic signed [31:0] HUM_MAX = 32'sd419430400;

  typedef struct packed {
    logic en;
    logic vld;
  } div_ctl_t;

endpackage

@@ hdl/src_div.sv @@
module src_div
  import src_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  div_ctl_t                    ctl,
  input  logic signed [NUM_W-1:0]     num,
  input  logic signed [DEN_W-1:0]     den,
  input  logic [DIV_TAG_W-1:0]        tag_in,
  output logic                        out_vld,
  output logic signed [NUM_W-1:0]     quot,
  output logic                        div_zero,
  output logic [DIV_TAG_W-1:0]        tag_out
);

  // Stage 0 takes magnitudes, stages 1..NUM_W each retire one quotient bit,
  // and the output stage restores the sign.
  logic [NUM_W:0]       vld;
  logic [DEN_W-1:0]     rem   [NUM_W+1];
  logic [NUM_W-1:0]     nq    [NUM_W+1];
  logic [DEN_W-1:0]     ad    [NUM_W+1];
  logic [NUM_W:0]       neg;
  logic [NUM_W:0]       zer;
  logic [DIV_TAG_W-1:0] tag   [NUM_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (ctl.en) begin
      vld[0] <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      rem[0] <= '0;
      nq[0]  <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      ad[0]  <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
      neg[0] <= num[NUM_W-1] ^ den[DEN_W-1];
      zer[0] <= (den == '0);
      tag[0] <= tag_in;
    end
  end

  for (genvar k = 0; k < NUM_W; k++) begin : g_step
    logic [DEN_W:0] trial;
    logic           take;
    assign trial = {rem[k], nq[k][NUM_W-1]};
    assign take  = (trial >= {1'b0, ad[k]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (ctl.en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rem[k+1] <= take ? DEN_W'(trial - {1'b0, ad[k]}) : trial[DEN_W-1:0];
        nq[k+1]  <= {nq[k][NUM_W-2:0], take};
        ad[k+1]  <= ad[k];
        neg[k+1] <= neg[k];
        zer[k+1] <= zer[k];
        tag[k+1] <= tag[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (ctl.en) begin
      out_vld <= vld[NUM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (zer[NUM_W]) begin
        quot <= '0;
      end else begin
        quot <= neg[NUM_W] ? -$signed(nq[NUM_W]) : $signed(nq[NUM_W]);
      end
      div_zero <= zer[NUM_W];
      tag_out  <= tag[NUM_W];
    end
  end

endmodule

@@ hdl/sensor_raw_compensation_unit.sv @@
// Channel  | Signals                         | Moves
// ---------+---------------------------------+-----------------------------------
// in       | in_valid, in_stall, in_data     | one raw reading per transfer
// out      | out_valid, out_stall, out_data  | one compensated reading per transfer
// cfg      | cfg_we, cfg_index, cfg_data     | calibration word write, one cycle
//
// One reading enters per cycle while the output is not stalled; the
// one-bit-per-stage 64-bit pressure divider sits between the front and back math.
// Reset clears only the valid bits and the calibration words.
// A stalled output freezes the whole pipeline and stalls the input in the same cycle.
module sensor_raw_compensation_unit
  import src_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [47:0] calib_temp, calib_press_a, calib_press_b, calib_press_c;
  logic [31:0] calib_hum_a;
  logic [39:0] calib_hum_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      calib_temp    <= '0;
      calib_press_a <= '0;
      calib_press_b <= '0;
      calib_press_c <= '0;
      calib_hum_a   <= '0;
      calib_hum_b   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CALIB_TEMP:    calib_temp    <= cfg_data[47:0];
        CFG_CALIB_PRESS_A: calib_press_a <= cfg_data[47:0];
        CFG_CALIB_PRESS_B: calib_press_b <= cfg_data[47:0];
        CFG_CALIB_PRESS_C: calib_press_c <= cfg_data[47:0];
        CFG_CALIB_HUM_A:   calib_hum_a   <= cfg_data[31:0];
        CFG_CALIB_HUM_B:   calib_hum_b   <= cfg_data[39:0];
        default: ;
      endcase
    end
  end

  // Coefficients widened to the width of the arithmetic that uses them.
  logic signed [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
  logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = 32'($signed({1'b0, calib_temp[15:0]}));
  assign t2 = 32'($signed(calib_temp[31:16]));
  assign t3 = 32'($signed(calib_temp[47:32]));
  assign p1 = 64'($signed({1'b0, calib_press_a[15:0]}));
  assign p2 = 64'($signed(calib_press_a[31:16]));
  assign p3 = 64'($signed(calib_press_a[47:32]));
  assign p4 = 64'($signed(calib_press_b[15:0]));
  assign p5 = 64'($signed(calib_press_b[31:16]));
  assign p6 = 64'($signed(calib_press_b[47:32]));
  assign p7 = 64'($signed(calib_press_c[15:0]));
  assign p8 = 64'($signed(calib_press_c[31:16]));
  assign p9 = 64'($signed(calib_press_c[47:32]));
  assign h1 = 32'($signed({1'b0, calib_hum_a[7:0]}));
  assign h3 = 32'($signed({1'b0, calib_hum_a[15:8]}));
  assign h2 = 32'($signed(calib_hum_a[31:16]));
  assign h4 = 32'($signed(calib_hum_b[15:0]));
  assign h5 = 32'($signed(calib_hum_b[31:16]));
  assign h6 = 32'($signed(calib_hum_b[39:32]));

  logic en;
  assign in_stall = out_valid && out_stall;
  assign en       = !in_stall;

  logic [10:1] vld;
  logic a_vld, b_vld, c_vld;

  logic [19:0]        r_adp [1:8];
  logic [15:0]        r_adh [1:7];
  logic signed [31:0] r_temp [5:10];
  logic signed [31:0] r_x [7:10];

  logic signed [31:0] s1_ta, s1_tb, s2_m1, s2_m2, s3_v1t, s3_m3, s4_fine;
  logic signed [33:0] s5_pv1;
  logic signed [31:0] s5_hv;
  logic signed [63:0] s6_sq, s6_pm5, s6_pm2;
  logic signed [31:0] s6_hm5, s6_hm6, s6_hm3;
  logic signed [63:0] s7_v2a, s7_v1a, s7_pm5, s7_pm2;
  logic signed [31:0] s7_y1;
  logic signed [63:0] s8_v2, s8_v1b;
  logic signed [31:0] s8_y2;
  logic signed [63:0] s9_pv, s9_num0;
  logic signed [31:0] s9_ym;
  logic signed [DEN_W-1:0] s10_den;
  logic signed [63:0] s10_num;
  logic signed [31:0] s10_y;

  logic signed [31:0] adt32;
  logic signed [63:0] pv1_64, adp64;
  logic signed [31:0] adh32;

  assign adt32  = 32'($signed({1'b0, in_data.raw_temp}));
  assign pv1_64 = 64'(s5_pv1);
  assign adp64  = 64'($signed({1'b0, r_adp[8]}));
  assign adh32  = 32'($signed({1'b0, r_adh[6]}));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[9:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_adp[1] <= in_data.raw_press;
      r_adh[1] <= in_data.raw_hum;
      for (int i = 2; i <= 8; i++) r_adp[i] <= r_adp[i-1];
      for (int i = 2; i <= 7; i++) r_adh[i] <= r_adh[i-1];
      for (int i = 6; i <= 10; i++) r_temp[i] <= r_temp[i-1];
      for (int i = 8; i <= 10; i++) r_x[i] <= r_x[i-1];

      // Temperature.
      s1_ta   <= (adt32 >>> 3) - (t1 <<< 1);
      s1_tb   <= (adt32 >>> 4) - t1;
      s2_m1   <= s1_ta * t2;
      s2_m2   <= s1_tb * s1_tb;
      s3_v1t  <= s2_m1 >>> 11;
      s3_m3   <= (s2_m2 >>> 12) * t3;
      s4_fine <= s3_v1t + (s3_m3 >>> 14);

      r_temp[5] <= ((s4_fine <<< 2) + s4_fine + 32'sd128) >>> 8;
      s5_pv1    <= 34'(s4_fine) - 34'sd128000;
      s5_hv     <= s4_fine - 32'sd76800;

      // Pressure front end and humidity, side by side.
      s6_sq  <= pv1_64 * pv1_64;
      s6_pm5 <= pv1_64 * p5;
      s6_pm2 <= pv1_64 * p2;
      s6_hm5 <= s5_hv * h5;
      s6_hm6 <= s5_hv * h6;
      s6_hm3 <= s5_hv * h3;

      s7_v2a <= s6_sq * p6;
      s7_v1a <= s6_sq * p3;
      s7_pm5 <= s6_pm5;
      s7_pm2 <= s6_pm2;
      r_x[7] <= ((adh32 <<< 14) - (h4 <<< 20) - s6_hm5 + 32'sd16384) >>> 15;
      s7_y1  <= (s6_hm6 >>> 10) * ((s6_hm3 >>> 11) + 32'sd32768);

      s8_v2  <= s7_v2a + (s7_pm5 <<< 17) + (p4 <<< 35);
      s8_v1b <= (s7_v1a >>> 8) + (s7_pm2 <<< 12);
      s8_y2  <= (s7_y1 >>> 10) + 32'sd2097152;

      s9_pv   <= (64'sh0000_8000_0000_0000 + s8_v1b) * p1;
      s9_num0 <= ((64'sd1048576 - adp64) <<< 31) - s8_v2;
      s9_ym   <= s8_y2 * h2;

      s10_den <= DEN_W'(s9_pv >>> 33);
      s10_num <= s9_num0 * 64'sd3125;
      s10_y   <= (s9_ym + 32'sd8192) >>> 14;
    end
  end

  div_ctl_t                dctl;
  logic                    d_vld, d_zero;
  logic signed [63:0]      d_quot;
  logic [DIV_TAG_W-1:0]    d_tag;

  assign dctl.en  = en;
  assign dctl.vld = vld[10];

  src_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (dctl),
    .num      (s10_num),
    .den      (s10_den),
    .tag_in   ({r_temp[10], r_x[10], s10_y}),
    .out_vld  (d_vld),
    .quot     (d_quot),
    .div_zero (d_zero),
    .tag_out  (d_tag)
  );

  // Back end: pressure correction and humidity, four stages.
  logic signed [63:0] a_p, a_q, a_pq, a_w2;
  logic signed [31:0] a_hvv, a_temp;
  logic               a_zero;
  logic signed [63:0] b_p, b_w2;
  logic [63:0]        b_ll;
  logic [31:0]        b_hl, b_lh;
  logic signed [31:0] b_hvv, b_sq2, b_temp;
  logic               b_zero;
  logic signed [63:0] c_p, c_w1, c_w2;
  logic signed [31:0] c_hvv, c_t, c_temp;
  logic               c_zero;
  logic signed [63:0] c_pqq;
  logic signed [31:0] b_s, c_hum, d_press;
  logic signed [63:0] d_sum;

  assign b_s   = a_hvv >>> 15;
  assign c_pqq = $signed(b_ll + {(b_hl + b_lh), 32'b0});
  assign d_sum = ((c_p + c_w1 + c_w2) >>> 8) + (p7 <<< 4);
  assign c_hum = c_hvv - (c_t >>> 4);
  assign d_press = d_sum[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld     <= 1'b0;
      b_vld     <= 1'b0;
      c_vld     <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_vld     <= d_vld;
      b_vld     <= a_vld;
      c_vld     <= b_vld;
      out_valid <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_p    <= d_quot;
      a_q    <= d_quot >>> 13;
      a_pq   <= p9 * (d_quot >>> 13);
      a_w2   <= (p8 * d_quot) >>> 19;
      a_hvv  <= $signed(d_tag[63:32]) * $signed(d_tag[31:0]);
      a_temp <= $signed(d_tag[95:64]);
      a_zero <= d_zero;

      // Low 64 bits of a 64 by 64 product from 32-bit partial products.
      b_ll   <= 64'(a_pq[31:0]) * 64'(a_q[31:0]);
      b_hl   <= 32'(a_pq[63:32] * a_q[31:0]);
      b_lh   <= 32'(a_pq[31:0] * a_q[63:32]);
      b_p    <= a_p;
      b_w2   <= a_w2;
      b_hvv  <= a_hvv;
      b_sq2  <= b_s * b_s;
      b_temp <= a_temp;
      b_zero <= a_zero;

      c_w1   <= c_pqq >>> 25;
      c_p    <= b_p;
      c_w2   <= b_w2;
      c_hvv  <= b_hvv;
      c_t    <= (b_sq2 >>> 7) * h1;
      c_temp <= b_temp;
      c_zero <= b_zero;

      out_data.temp_centi    <= c_temp;
      out_data.press_q24_8   <= c_zero ? 32'd0 : 32'(unsigned'(d_press));
      out_data.press_invalid <= c_zero;
      if (c_hum < 0) begin
        out_data.hum_q22_10 <= '0;
      end else if (c_hum > HUM_MAX) begin
        out_data.hum_q22_10 <= HUM_MAX[28:12];
      end else begin
        out_data.hum_q22_10 <= c_hum[28:12];
      end
    end
  end

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.press_invalid |-> out_data.press_q24_8 == 32'd0)
    else $error("pressure not forced to zero on a zero divisor");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.hum_q22_10 <= 17'd102400)
    else $error("humidity above the clamp");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> vld[1])
    else $error("accepted reading lost at pipeline entry");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> $stable(vld) && $stable(c_vld))
    else $error("pipeline moved while stalled");

endmodule

@@ tb/comp_checker.sv @@
module comp_checker
  import src_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_stall,
  input  in_item_t         in_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int               errors,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [47:0] cal_temp, cal_pa, cal_pb, cal_pc;
  logic [31:0] cal_ha;
  logic [39:0] cal_hb;
  out_item_t   expected_q[$];

  function automatic out_item_t compensate(in_item_t r);
    logic signed [31:0] adt, adh, t1, t2, t3, a, b, v1t, v2t, fine, temp;
    logic signed [31:0] h1, h2, h3, h4, h5, h6, hv, x, y, s, hm;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [63:0] v1, v2, pp, q, w1, w2, num;
    logic [63:0]        an, ad, uq;
    out_item_t          o;
    adt = {12'b0, r.raw_temp};
    adh = {16'b0, r.raw_hum};
    t1 = {16'b0, cal_temp[15:0]};
    t2 = $signed(cal_temp[31:16]);
    t3 = $signed(cal_temp[47:32]);
    p1 = {48'b0, cal_pa[15:0]};
    p2 = $signed(cal_pa[31:16]);
    p3 = $signed(cal_pa[47:32]);
    p4 = $signed(cal_pb[15:0]);
    p5 = $signed(cal_pb[31:16]);
    p6 = $signed(cal_pb[47:32]);
    p7 = $signed(cal_pc[15:0]);
    p8 = $signed(cal_pc[31:16]);
    p9 = $signed(cal_pc[47:32]);
    h1 = {24'b0, cal_ha[7:0]};
    h3 = {24'b0, cal_ha[15:8]};
    h2 = $signed(cal_ha[31:16]);
    h4 = $signed(cal_hb[15:0]);
    h5 = $signed(cal_hb[31:16]);
    h6 = $signed(cal_hb[39:32]);

    a    = (adt >>> 3) - (t1 <<< 1);
    v1t  = (a * t2) >>> 11;
    b    = (adt >>> 4) - t1;
    v2t  = (((b * b) >>> 12) * t3) >>> 14;
    fine = v1t + v2t;
    temp = (fine * 32'sd5 + 32'sd128) >>> 8;

    v1 = fine;
    v1 = v1 - 64'sd128000;
    v2 = v1 * v1 * p6 + ((v1 * p5) <<< 17) + (p4 <<< 35);
    v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
    v1 = ((64'sh0000800000000000 + v1) * p1) >>> 33;
    o.temp_centi = temp;
    if (v1 == 0) begin
      o.press_q24_8   = '0;
      o.press_invalid = 1'b1;
    end else begin
      pp  = 64'sd1048576 - $signed({44'b0, r.raw_press});
      num = ((pp <<< 31) - v2) * 64'sd3125;
      // Truncating divide on magnitudes; the most negative value over -1 wraps.
      an  = num[63] ? 64'(-num) : 64'(num);
      ad  = v1[63] ? 64'(-v1) : 64'(v1);
      uq  = an / ad;
      pp  = (num[63] ^ v1[63]) ? $signed(-uq) : $signed(uq);
      q   = pp >>> 13;
      w1  = (p9 * q * q) >>> 25;
      w2  = (p8 * pp) >>> 19;
      pp  = ((pp + w1 + w2) >>> 8) + (p7 <<< 4);
      o.press_q24_8   = pp[31:0];
      o.press_invalid = 1'b0;
    end

    hv = fine - 32'sd76800;
    x  = (adh <<< 14) - (h4 <<< 20) - (h5 * hv);
    x  = (x + 32'sd16384) >>> 15;
    y  = ((hv * h6) >>> 10) * (((hv * h3) >>> 11) + 32'sd32768);
    y  = (y >>> 10) + 32'sd2097152;
    y  = (y * h2 + 32'sd8192) >>> 14;
    hm = x * y;
    s  = hm >>> 15;
    hm = hm - ((((s * s) >>> 7) * h1) >>> 4);
    if (hm < 0) hm = 0;
    else if (hm > HUM_MAX) hm = HUM_MAX;
    o.hum_q22_10 = hm[28:12];
    return o;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      cal_temp <= '0; cal_pa <= '0; cal_pb <= '0;
      cal_pc <= '0; cal_ha <= '0; cal_hb <= '0;
      expected_q.delete();
      errors <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CALIB_TEMP:    cal_temp <= cfg_data[47:0];
          CFG_CALIB_PRESS_A: cal_pa   <= cfg_data[47:0];
          CFG_CALIB_PRESS_B: cal_pb   <= cfg_data[47:0];
          CFG_CALIB_PRESS_C: cal_pc   <= cfg_data[47:0];
          CFG_CALIB_HUM_A:   cal_ha   <= cfg_data[31:0];
          CFG_CALIB_HUM_B:   cal_hb   <= cfg_data[39:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_q.push_back(compensate(in_data));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          if (errors < 10) $display("unexpected result transfer: %p", out_data);
          errors <= errors + 1;
        end else begin
          e = expected_q.pop_front();
          if (e !== out_data) begin
            if (errors < 10) $display("result mismatch: expected %p, got %p", e, out_data);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

@@ tb/tb_top.sv @@
module tb_top;
  import src_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic             clk = 1'b0;
  logic             rst;
  logic             in_valid, in_stall, out_valid, out_stall;
  in_item_t         in_data;
  out_item_t        out_data;
  logic             cfg_we;
  logic [2:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int               errors, pending;
  int               stall_level;

  always #10 clk = ~clk;

  sensor_raw_compensation_unit u_dut (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_we, .cfg_index, .cfg_data
  );

  comp_checker u_chk (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_we, .cfg_index, .cfg_data, .errors, .pending
  );

  // The receiver switches among four stall density levels,
  // including one with no stall at all.
  always @(posedge clk) begin
    int cnt;
    if (rst) begin
      out_stall <= 1'b0;
      stall_level <= 0;
      cnt = 0;
    end else begin
      cnt++;
      if (cnt % 300 == 0) stall_level <= $urandom_range(0, 3);
      case (stall_level)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ((cnt / 7) % 2 == 0);
      endcase
    end
  end

  task automatic send(in_item_t r);
    logic taken;
    in_data  <= r;
    in_valid <= 1'b1;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic idle_gap();
    int gap;
    if ($urandom_range(0, 2) != 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic load_calib(logic [47:0] t, pa, pb, pc, logic [31:0] ha, logic [39:0] hb);
    logic [47:0] vals[6];
    vals = '{t, pa, pb, pc, {16'b0, ha}, {8'b0, hb}};
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic in_item_t rand_item(bit plausible);
    in_item_t r;
    if (plausible) begin
      r.raw_press = 20'($urandom_range(250000, 600000));
      r.raw_temp  = 20'($urandom_range(400000, 650000));
      r.raw_hum   = 16'($urandom_range(15000, 50000));
    end else begin
      r.raw_press = 20'($urandom());
      r.raw_temp  = 20'($urandom());
      r.raw_hum   = 16'($urandom());
    end
    return r;
  endfunction

  task automatic random_run(int n, bit plausible);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst && n > 0; i++, n--) send(rand_item(plausible));
      idle_gap();
    end
  endtask

  task automatic directed_run();
    logic [19:0] pv[4] = '{20'h00000, 20'hFFFFF, 20'h65A2C, 20'h7EED0};
    logic [15:0] hv[3] = '{16'h0000, 16'hFFFF, 16'h6EBE};
    in_item_t r;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 3; j++) begin
        r.raw_press = pv[i];
        r.raw_temp  = pv[3 - i];
        r.raw_hum   = hv[j];
        send(r);
      end
  endtask

  initial begin
    logic [47:0] typ_t, typ_pa, typ_pb, typ_pc;
    logic [31:0] typ_ha;
    logic [39:0] typ_hb;
    in_valid <= 1'b0;
    in_data  <= '0;
    cfg_we   <= 1'b0;
    cfg_index <= CFG_CALIB_TEMP;
    cfg_data <= '0;
    rst      <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset calibration leaves a zero pressure divisor.
    directed_run();
    drain();

    typ_t  = {16'hFC18, 16'd26435, 16'd27504};
    typ_pa = {16'd3024, 16'hD643, 16'd36477};
    typ_pb = {16'hFFF9, 16'd140, 16'd2855};
    typ_pc = {16'd6000, 16'hC6F8, 16'd15500};
    typ_ha = {16'd362, 8'd0, 8'd75};
    typ_hb = {8'd30, 16'd50, 16'd321};
    load_calib(typ_t, typ_pa, typ_pb, typ_pc, typ_ha, typ_hb);
    // Writes to an unused index must leave the calibration alone.
    cfg_we <= 1'b1; cfg_index <= 3'd6; cfg_data <= '1;
    @(posedge clk);
    cfg_we <= 1'b0;
    directed_run();
    random_run(300, 1);
    // Let the pipeline empty completely in the middle of the traffic.
    drain();
    random_run(200, 0);
    drain();

    load_calib('1, '1, '1, '1, '1, '1);
    directed_run();
    random_run(150, 0);
    drain();

    load_calib(48'h7FFF7FFF7FFF, 48'h7FFF7FFF7FFF, 48'h7FFF7FFF7FFF,
               48'h7FFF7FFF7FFF, 32'h7FFFFFFF, 40'h7F7FFF7FFF);
    random_run(150, 0);
    drain();

    load_calib(48'h800080008000, 48'h80008000FFFF, 48'h800080008000,
               48'h800080008000, 32'h8000FFFF, 40'h8080008000);
    random_run(150, 0);
    drain();

    for (int k = 0; k < 6; k++) begin
      if (k % 2 == 0)
        load_calib(rand48(), rand48(), rand48(), rand48(), $urandom(), 40'(rand48()));
      else
        load_calib(typ_t ^ 48'($urandom_range(0, 255)), typ_pa ^ 48'($urandom_range(0, 255)),
                   typ_pb ^ 48'($urandom_range(0, 255)), typ_pc ^ 48'($urandom_range(0, 255)),
                   typ_ha ^ 32'($urandom_range(0, 255)), typ_hb ^ 40'($urandom_range(0, 255)));
      random_run(140, k % 2);
      drain();
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

@@ sim.f @@
hdl/src_pkg.sv
hdl/src_div.sv
hdl/sensor_raw_compensation_unit.sv
tb/comp_checker.sv
tb/tb_top.sv
